// ===== rtl/core/cpg_pkg.sv =====
// Shared constants, types and opcodes for the circle point generator.
package cpg_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned OUT_BITS   = COORD_BITS + 1;
  localparam int unsigned SC_BITS    = COORD_BITS + 2;
  localparam int unsigned DEC_BITS   = COORD_BITS + 6;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic signed [SC_BITS-1:0]    sc_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic signed [OUT_BITS-1:0]   point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   half;
    logic   done;
  } job_t;

endpackage

// ===== rtl/core/cpg_front.sv =====
// Front end: accepts words, holds the arc state and issues one job per step of a running arc.
module cpg_front
  import cpg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  logic   opcode_i,
  input  coord_t radius_i,
  input  logic   half_arc_i,
  input  logic   q_full_i,
  output logic   push_o,
  output job_t   job_o
);

  sc_t  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  sc_t  x_nx, y_nx, diff;
  dec_t dec_q, dec_d, dec_nx;
  logic active_q, active_d;
  logic half_q, half_d;
  logic accept;
  logic done;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    x_nx = cur_x_q + sc_t'(1);
    diff = '0;
    if (dec_q > dec_t'(0)) begin
      y_nx   = cur_y_q - sc_t'(1);
      diff   = x_nx - y_nx;
      dec_nx = dec_q + (dec_t'(diff) <<< 2) + dec_t'(10);
    end else begin
      y_nx   = cur_y_q;
      dec_nx = dec_q + (dec_t'(x_nx) <<< 2) + dec_t'(6);
    end
    done = (y_nx < x_nx);
  end

  assign push_o = accept && (opcode_i == OP_STEP) && active_q;

  always_comb begin
    job_o.x    = cur_x_q[COORD_BITS-1:0];
    job_o.y    = cur_y_q[COORD_BITS-1:0];
    job_o.half = half_q;
    job_o.done = done;
  end

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    dec_d    = dec_q;
    active_d = active_q;
    half_d   = half_q;
    if (accept && (opcode_i == OP_START)) begin
      cur_x_d  = '0;
      cur_y_d  = sc_t'(radius_i);
      dec_d    = dec_t'(3) - (dec_t'(radius_i) <<< 1);
      half_d   = half_arc_i;
      active_d = 1'b1;
    end else if (push_o) begin
      cur_x_d = x_nx;
      cur_y_d = y_nx;
      dec_d   = dec_nx;
      if (done) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      dec_q    <= '0;
      active_q <= 1'b0;
      half_q   <= 1'b0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      dec_q    <= dec_d;
      active_q <= active_d;
      half_q   <= half_d;
    end
  end

endmodule

// ===== rtl/core/cpg_queue.sv =====
// Two-entry job queue between the front end and the point emitter.
module cpg_queue
  import cpg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/cpg_back.sv =====
// Back end: expands each job into its symmetric points, one word per cycle while the output is not stalled.
module cpg_back
  import cpg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_empty_i,
  input  job_t   q_job_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output point_t point_x_o,
  output point_t point_y_o,
  output logic   last_of_step_o,
  output logic   arc_done_o
);

  job_t       job_q;
  logic       busy_q;
  logic [2:0] idx_q;
  logic [2:0] sel;
  logic       adv, emit, last;
  point_t     a_ext, b_ext;
  point_t     out_x_q, out_y_q;
  logic       out_valid_q, out_last_q, out_done_q;

  assign adv  = !out_valid_q || !out_stall_i;
  assign emit = busy_q && adv;
  assign last = job_q.half ? (idx_q == 3'd3) : (idx_q == 3'd7);
  assign sel  = job_q.half ? {idx_q[1], 1'b0, idx_q[0]} : idx_q;

  assign pop_o = !q_empty_i && (!busy_q || (emit && last));

  always_comb begin
    if (sel[2]) begin
      a_ext = point_t'({1'b0, job_q.y});
      b_ext = point_t'({1'b0, job_q.x});
    end else begin
      a_ext = point_t'({1'b0, job_q.x});
      b_ext = point_t'({1'b0, job_q.y});
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_job_i;
    end
    if (emit) begin
      out_x_q    <= sel[0] ? -a_ext : a_ext;
      out_y_q    <= sel[1] ? -b_ext : b_ext;
      out_last_q <= last;
      out_done_q <= last && job_q.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 3'd0;
      end else if (emit) begin
        idx_q <= idx_q + 3'd1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = out_x_q;
  assign point_y_o      = out_y_q;
  assign last_of_step_o = out_last_q;
  assign arc_done_o     = out_done_q;

endmodule

// ===== rtl/core/circle_point_generator_top.sv =====
// Top level of the circle point generator: front end, job queue and point emitter.
// A step word passes through a queue entry, the back-end job register and the output
// register, then gives one point a cycle while the output is not stalled: eight points
// in full mode and four in half mode. Start words give no point; the queue holds steps while points emit.
// Reset is asynchronous and active low; it clears the arc state, the queue and the output.
module circle_point_generator_top
  import cpg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  logic   opcode_i,
  input  coord_t radius_i,
  input  logic   half_arc_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output point_t point_x_o,
  output point_t point_y_o,
  output logic   last_of_step_o,
  output logic   arc_done_o
);

  job_t push_job, head_job;
  logic push, pop, q_full, q_empty;

  cpg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .radius_i   (radius_i),
    .half_arc_i (half_arc_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  cpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (head_job)
  );

  cpg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_job_i        (head_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .last_of_step_o (last_of_step_o),
    .arc_done_o     (arc_done_o)
  );

endmodule

// ===== verif/cpg_point_checker.sv =====
// Checker for the circle point generator: predicts every point from the accepted words and compares.
module cpg_point_checker
  import cpg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   in_stall_i,
  input  logic   opcode_i,
  input  coord_t radius_i,
  input  logic   half_arc_i,
  input  logic   out_valid_i,
  input  logic   out_stall_i,
  input  point_t point_x_i,
  input  point_t point_y_i,
  input  logic   last_of_step_i,
  input  logic   arc_done_i,
  output int     mismatches_o,
  output int     outstanding_o
);

  typedef struct packed {
    point_t x;
    point_t y;
    logic   last;
    logic   done;
  } arc_point_t;

  arc_point_t expected_points[$];
  sc_t        arc_x;
  sc_t        arc_y;
  dec_t       arc_d;
  logic       arc_busy;
  logic       arc_half;
  int         mismatch_count;

  task automatic rasterise_word(input logic op, input coord_t rad, input logic half);
    point_t sx[8];
    point_t sy[8];
    sc_t    nx;
    sc_t    ny;
    int     cnt;
    int     idx;
    logic   finished;
    if (op == OP_START) begin
      arc_x    = '0;
      arc_y    = sc_t'(rad);
      arc_d    = dec_t'(3 - 2 * int'(rad));
      arc_half = half;
      arc_busy = 1'b1;
    end else if (arc_busy) begin
      sx[0] = point_t'(arc_x);  sy[0] = point_t'(arc_y);
      sx[1] = point_t'(-arc_x); sy[1] = point_t'(arc_y);
      sx[2] = point_t'(arc_x);  sy[2] = point_t'(-arc_y);
      sx[3] = point_t'(-arc_x); sy[3] = point_t'(-arc_y);
      sx[4] = point_t'(arc_y);  sy[4] = point_t'(arc_x);
      sx[5] = point_t'(-arc_y); sy[5] = point_t'(arc_x);
      sx[6] = point_t'(arc_y);  sy[6] = point_t'(-arc_x);
      sx[7] = point_t'(-arc_y); sy[7] = point_t'(-arc_x);
      nx = arc_x + sc_t'(1);
      ny = arc_y;
      if (arc_d > 0) begin
        ny    = arc_y - sc_t'(1);
        arc_d = dec_t'(arc_d + 4 * (nx - ny) + 10);
      end else begin
        arc_d = dec_t'(arc_d + 4 * nx + 6);
      end
      arc_x    = nx;
      arc_y    = ny;
      finished = (ny < nx);
      if (finished) begin
        arc_busy = 1'b0;
      end
      cnt = arc_half ? 4 : 8;
      for (int k = 0; k < cnt; k++) begin
        // The upper half keeps the first two points of each octant pair.
        idx = (arc_half && k >= 2) ? k + 2 : k;
        expected_points.push_back('{sx[idx], sy[idx], logic'(k == cnt - 1),
                                    logic'((k == cnt - 1) && finished)});
      end
    end
  endtask

  task automatic compare_point();
    arc_point_t want;
    if (expected_points.size() == 0) begin
      $display("%0t: unexpected point (%0d, %0d) last %b done %b, expected nothing", $time,
               point_x_i, point_y_i, last_of_step_i, arc_done_i);
      mismatch_count++;
    end else begin
      want = expected_points.pop_front();
      if (point_x_i !== want.x) begin
        $display("%0t: point_x mismatch, expected %0d, actual %0d", $time, want.x, point_x_i);
        mismatch_count++;
      end
      if (point_y_i !== want.y) begin
        $display("%0t: point_y mismatch, expected %0d, actual %0d", $time, want.y, point_y_i);
        mismatch_count++;
      end
      if (last_of_step_i !== want.last) begin
        $display("%0t: last_of_step mismatch, expected %b, actual %b", $time, want.last,
                 last_of_step_i);
        mismatch_count++;
      end
      if (arc_done_i !== want.done) begin
        $display("%0t: arc_done mismatch, expected %b, actual %b", $time, want.done,
                 arc_done_i);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arc_x          = '0;
      arc_y          = '0;
      arc_d          = '0;
      arc_busy       = 1'b0;
      arc_half       = 1'b0;
      mismatch_count = 0;
      expected_points.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        compare_point();
      end
      if (in_valid_i && !in_stall_i) begin
        rasterise_word(opcode_i, radius_i, half_arc_i);
      end
      mismatches_o  <= mismatch_count;
      outstanding_o <= expected_points.size();
    end
  end

endmodule

// ===== verif/tb_circle_point_generator_top.sv =====
// Testbench top for the circle point generator: clock, reset, word stimulus and verdict.
module tb_circle_point_generator_top;
  import cpg_pkg::*;

  localparam int unsigned TOTAL_WORDS  = 450;
  localparam int unsigned CYCLE_LIMIT  = 1500000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        opcode;
  coord_t      radius;
  logic        half_arc;
  logic        out_valid;
  logic        out_stall;
  point_t      point_x;
  point_t      point_y;
  logic        last_of_step;
  logic        arc_done;
  int          mismatches;
  int          outstanding;
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  bit          hold_request = 1'b0;
  bit          calm_sender  = 1'b0;

  circle_point_generator_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .radius_i       (radius),
    .half_arc_i     (half_arc),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .point_x_o      (point_x),
    .point_y_o      (point_y),
    .last_of_step_o (last_of_step),
    .arc_done_o     (arc_done)
  );

  cpg_point_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .opcode_i       (opcode),
    .radius_i       (radius),
    .half_arc_i     (half_arc),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .last_of_step_i (last_of_step),
    .arc_done_i     (arc_done),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver alternates free and stalled runs; a hold request gives one long stall.
  initial begin
    int unsigned run_len;
    int unsigned pick;
    bit          run_stalled;
    run_len     = 0;
    run_stalled = 1'b0;
    out_stall  <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        run_stalled  = 1'b1;
        run_len      = HOLD_CYCLES;
      end else if (run_len == 0) begin
        pick        = $urandom_range(0, 99);
        run_stalled = (pick >= 55);
        if (pick < 50) begin
          run_len = $urandom_range(1, 12);
        end else if (pick < 55) begin
          run_len = $urandom_range(40, 160);
        end else if (pick < 90) begin
          run_len = $urandom_range(1, 3);
        end else if (pick < 98) begin
          run_len = $urandom_range(4, 12);
        end else begin
          run_len = $urandom_range(25, 70);
        end
      end
      out_stall <= run_stalled;
      run_len = run_len - 1;
    end
  end

  task automatic sender_gap();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (calm_sender || pick < 55) begin
      len = 0;
    end else if (pick < 90) begin
      len = $urandom_range(1, 3);
    end else if (pick < 98) begin
      len = $urandom_range(4, 12);
    end else begin
      len = $urandom_range(20, 60);
    end
    if (len != 0) begin
      in_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic send_word(input logic op, input coord_t rad, input logic half);
    in_valid <= 1'b1;
    opcode   <= op;
    radius   <= rad;
    half_arc <= half;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    sender_gap();
  endtask

  task automatic draw_arc(input coord_t rad, input logic half, input int unsigned steps);
    send_word(OP_START, rad, half);
    repeat (steps) send_word(OP_STEP, coord_t'($urandom), logic'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned pick;
    int unsigned steps;
    coord_t      rad;
    bit          pressure_done;
    pressure_done = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    opcode   <= OP_START;
    radius   <= '0;
    half_arc <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A step before any start gives nothing.
    send_word(OP_STEP, '1, 1'b1);
    draw_arc(coord_t'(0), 1'b0, 2);
    draw_arc(coord_t'(0), 1'b1, 1);
    // Several of the following starts abandon the arc left running before them.
    draw_arc(coord_t'(1023), 1'b1, 2);
    draw_arc(coord_t'(1), 1'b0, 1);
    draw_arc(coord_t'(5), 1'b0, 1);
    draw_arc(coord_t'(3), 1'b1, 3);
    draw_arc(coord_t'(682), 1'b0, 1);
    draw_arc(coord_t'(341), 1'b1, 1);
    wait_drained();

    while (words_sent < TOTAL_WORDS) begin
      if (!pressure_done && words_sent >= 180) begin
        calm_sender  = 1'b1;
        hold_request = 1'b1;
        draw_arc(coord_t'(90), 1'b0, 45);
        calm_sender   = 1'b0;
        pressure_done = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_word(logic'($urandom_range(0, 1)), coord_t'($urandom),
                  logic'($urandom_range(0, 1)));
      end else begin
        steps = $urandom_range(0, 99);
        if (steps < 75) begin
          rad = coord_t'($urandom_range(0, 24));
        end else if (steps < 93) begin
          rad = coord_t'($urandom_range(25, 100));
        end else begin
          rad = coord_t'($urandom_range(101, 1023));
        end
        // Roughly the number of steps that completes the arc.
        steps = int'(rad) * 7 / 10 + 2;
        if (pick < 20) begin
          steps = $urandom_range(0, steps);
        end else begin
          steps = steps + $urandom_range(0, 1);
        end
        if (steps > 40) begin
          steps = 40;
        end
        draw_arc(rad, logic'($urandom_range(0, 1)), steps);
      end
      if ($urandom_range(0, 19) == 0) begin
        calm_sender = !calm_sender;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cpg_pkg.sv
rtl/core/cpg_front.sv
rtl/core/cpg_queue.sv
rtl/core/cpg_back.sv
rtl/core/circle_point_generator_top.sv
verif/cpg_point_checker.sv
verif/tb_circle_point_generator_top.sv
